>>> src/s2t_pkg.sv
`timescale 1ns / 1ps
// s2t_pkg: character codes and the shared job type for the spaces-to-tabs converter.
// No dependencies.
package s2t_pkg;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Emission job: a run of spaces followed by one closing byte.
    typedef struct packed {
        logic       valid;
        logic [2:0] spaces;
        logic [7:0] tail;
    } s2t_job_t;

endpackage

>>> src/s2t_step.sv
`timescale 1ns / 1ps
// s2t_step: per-byte column tracking and emission decision (combinational).
// Depends on s2t_pkg.
module s2t_step
(
    input  logic [7:0]       text_byte,
    input  logic             first_of_string,
    input  logic [7:0]       start_column,
    input  logic [2:0]       phase,
    input  logic [2:0]       pending,
    output logic [2:0]       phase_next,
    output logic [2:0]       pending_next,
    output s2t_pkg::s2t_job_t job
);
    import s2t_pkg::*;

    logic [2:0] phase_base;
    logic [2:0] pending_base;
    logic       line_break;

    always_comb
    begin
        phase_base   = first_of_string ? start_column[2:0] : phase;
        pending_base = first_of_string ? 3'd0 : pending;
        line_break   = (text_byte == CH_NL) || (text_byte == CH_CR) || (text_byte == CH_FF);
        phase_next   = line_break ? 3'd0 : phase_base + 3'd1;

        job = '0;
        if (text_byte == CH_SPACE)
        begin
            if (phase_next == 3'd0)
            begin
                pending_next = 3'd0;
                job.valid    = 1'b1;
                job.spaces   = 3'd0;
                job.tail     = CH_TAB;
            end
            else
            begin
                pending_next = pending_base + 3'd1;
            end
        end
        else
        begin
            pending_next = 3'd0;
            job.valid    = 1'b1;
            job.spaces   = pending_base;
            job.tail     = text_byte;
        end
    end

endmodule

>>> src/spaces_to_tabs_converter.sv
`timescale 1ns / 1ps
// spaces_to_tabs_converter: top level, job register and output register.
// Depends on s2t_pkg and s2t_step.
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+----------------------
//  in      | text_byte[7:0], first_of_string, start_column  | in_valid / in_ready
//  out     | out_byte[7:0], last_of_run                     | out_valid / out_ready
//
// One result leaves per cycle while out_ready allows; a byte with n pending spaces gives n spaces, then itself.
// Bytes that cause no result (held spaces) are taken every cycle once no job is left in flight.
// The input side takes a new byte while the previous job hands over its final result.
// Reset clears column phase, pending count and both valid flags.
// A stalled output holds a valid job in the job register; in_ready drops until it can drain.
module spaces_to_tabs_converter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       first_of_string,
    input  logic [7:0] start_column,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);
    import s2t_pkg::*;

    logic [2:0] phase_reg;
    logic [2:0] pending_reg;
    logic [2:0] phase_next;
    logic [2:0] pending_next;
    s2t_job_t   job_reg;
    s2t_job_t   job_next;
    s2t_job_t   step_job;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       out_load;
    logic       job_done;
    logic       in_take;

    s2t_step u_step
    (
        .text_byte       (text_byte),
        .first_of_string (first_of_string),
        .start_column    (start_column),
        .phase           (phase_reg),
        .pending         (pending_reg),
        .phase_next      (phase_next),
        .pending_next    (pending_next),
        .job             (step_job)
    );

    assign out_load = !out_valid_reg || out_ready;
    assign job_done = job_reg.valid && (job_reg.spaces == 3'd0) && out_load;
    assign in_ready = !job_reg.valid || job_done;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        job_next = job_reg;
        if (in_take)
        begin
            job_next = step_job;
        end
        else if (job_done)
        begin
            job_next.valid = 1'b0;
        end
        else if (job_reg.valid && out_load)
        begin
            job_next.spaces = job_reg.spaces - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 3'd0;
            pending_reg   <= 3'd0;
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg   <= phase_next;
                pending_reg <= pending_next;
            end
            job_reg <= job_next;
            if (out_load)
            begin
                out_valid_reg <= job_reg.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && job_reg.valid)
        begin
            if (job_reg.spaces == 3'd0)
            begin
                out_byte_reg <= job_reg.tail;
                last_reg     <= 1'b1;
            end
            else
            begin
                out_byte_reg <= CH_SPACE;
                last_reg     <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

`ifndef SYNTHESIS
    a_idle_job_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !job_reg.valid |-> in_ready)
        else $error("input stalled with no job in flight");

    a_spaces_keep_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_reg.valid && (job_reg.spaces != 3'd0) && out_load |=> job_reg.valid)
        else $error("job retired with spaces still owed");

    a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |=> out_valid && last_of_run)
        else $error("closing byte not marked last");

    a_nonlast_is_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> out_byte == CH_SPACE)
        else $error("non-final result is not a space");
`endif

endmodule
